// ===== rtl/core/slsgd_pkg.sv =====
// ---------------------------------------------------------------------------
// slsgd_pkg: shared types and constants of the sigmoid layer trainer
// Sizes of the datapath, mode codes, sequencer states, lane controls and
// the constant functions that build the sigmoid table at elaboration.
// ---------------------------------------------------------------------------
`default_nettype none

package slsgd_pkg;

   localparam int NUM_FEATURES = 4;
   localparam int NUM_CLASSES  = 3;
   localparam int ROW_LEN      = NUM_FEATURES + 1;
   localparam int WEIGHT_COUNT = NUM_CLASSES * ROW_LEN;
   localparam int COL_W        = $clog2(ROW_LEN);
   localparam int F_W          = 16;
   localparam int X_W          = F_W + 1;
   localparam int W_W          = 24;
   localparam int ACT_W        = 16;
   localparam int LR_W         = 16;
   localparam int CNT_W        = 16;
   localparam int IDX_W        = 4;
   localparam int CLS_W        = $clog2(NUM_CLASSES);
   localparam int ACC_W        = W_W + X_W + $clog2(ROW_LEN) + 1;

   localparam logic signed [X_W-1:0] BIAS_X  = X_W'(4096);
   localparam logic signed [19:0]    SUM_MIN = 20'sh80000;
   localparam logic signed [19:0]    SUM_MAX = 20'sh7FFFF;
   localparam logic signed [W_W-1:0] W_MIN   = 24'sh800000;
   localparam logic signed [W_W-1:0] W_MAX   = 24'sh7FFFFF;
   localparam logic [LR_W-1:0]       LR_RESET = 16'd6554;
   localparam logic [CNT_W-1:0]      CNT_FULL = 16'hFFFF;

   localparam logic [1:0] MODE_TRAIN = 2'd0;
   localparam logic [1:0] MODE_INFER = 2'd1;
   localparam logic [1:0] MODE_LOAD  = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MAC,
      ST_SUM,
      ST_LOOK,
      ST_EVAL,
      ST_DELTA_A,
      ST_DELTA_B,
      ST_RATE,
      ST_UMUL,
      ST_UADD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_acc;
      logic mac_en;
      logic sum_en;
      logic look_en;
      logic delta_a_en;
      logic delta_b_en;
      logic rate_en;
      logic umul_en;
      logic uadd_en;
   } lane_ctrl_type;

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[63:0], num[b]};
         if (r >= {1'b0, den}) begin
            r = r - {1'b0, den};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [63:0] neg_exp(input logic [63:0] t);
      logic [63:0]        y;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        r;
      y    = (t << 16) >> 4;
      term = 64'd1 << 32;
      sum  = 64'sd1 <<< 32;
      for (int n = 1; n <= 12; n++) begin
         term = udiv64((term * y) >> 32, 64'(n));
         if ((n % 2) == 1) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      r = $unsigned(sum);
      if (r > 64'hFFFF_FFFF) begin
         r = 64'hFFFF_FFFF;
      end
      for (int i = 0; i < 4; i++) begin
         r = (r * r) >> 32;
      end
      return r;
   endfunction

   function automatic logic [ACT_W-1:0] sig_entry(input int k, input int depth);
      logic signed [63:0] m;
      logic [63:0]        mag;
      logic [63:0]        e;
      logic [63:0]        den;
      logic [63:0]        num;
      logic [63:0]        q;
      m   = -64'sd524288 + $signed(udiv64((64'(2 * k + 1)) << 19, 64'(depth)));
      mag = (m < 0) ? $unsigned(-m) : $unsigned(m);
      e   = neg_exp(mag);
      den = (64'd1 << 32) + e;
      num = (m >= 0) ? (64'd1 << 48) : (e << 16);
      q   = udiv64(num + (den >> 1), den);
      if (q > 64'd65535) begin
         q = 64'd65535;
      end
      return q[ACT_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/slsgd_lane.sv =====
// ---------------------------------------------------------------------------
// slsgd_lane: one neuron of the layer
// Holds one row of weights, accumulates the weighted sum one input per
// cycle, looks up the sigmoid, forms the delta and updates its weights.
// ---------------------------------------------------------------------------
`default_nettype none

module slsgd_lane #(
   parameter int SIGMOID_TABLE_DEPTH = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire slsgd_pkg::lane_ctrl_type            ctrl,
   input  wire logic [slsgd_pkg::COL_W-1:0]         col,
   input  wire logic signed [slsgd_pkg::X_W-1:0]    x_sel,
   input  wire logic                                target_bit,
   input  wire logic [slsgd_pkg::LR_W-1:0]          learning_rate,
   input  wire logic                                load_en,
   input  wire logic [slsgd_pkg::COL_W-1:0]         load_col,
   input  wire logic signed [slsgd_pkg::W_W-1:0]    load_value,
   output logic [slsgd_pkg::ACT_W-1:0]              activation
);
   import slsgd_pkg::*;

   localparam int AW = $clog2(SIGMOID_TABLE_DEPTH);
   localparam int DW = $clog2(SIGMOID_TABLE_DEPTH + 1);
   localparam logic [DW-1:0] DEPTH_U = DW'(SIGMOID_TABLE_DEPTH);

   logic [ACT_W-1:0] sig_tab [SIGMOID_TABLE_DEPTH];

   for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_tab
      localparam logic [ACT_W-1:0] ENTRY = sig_entry(k, SIGMOID_TABLE_DEPTH);
      assign sig_tab[k] = ENTRY;
   end

   logic signed [W_W-1:0]   w_ff [ROW_LEN];
   logic signed [ACC_W-1:0] acc_ff;
   logic [AW-1:0]           idx_ff;
   logic [ACT_W-1:0]        act_ff;
   logic signed [17:0]      err_ff;
   logic [30:0]             aa_ff;
   logic signed [16:0]      delta_ff;
   logic signed [33:0]      lrd_ff;
   logic signed [22:0]      step_ff;

   logic signed [W_W-1:0]        w_cur;
   logic signed [W_W+X_W-1:0]    mac_prod;
   logic signed [ACC_W-13:0]     sum_sh;
   logic signed [19:0]           sum_cl;
   logic [19:0]                  offs;
   logic [20+DW-1:0]             idx_prod;
   logic signed [17:0]           err_in;
   logic [32:0]                  aa_in;
   logic signed [49:0]           ep;
   logic signed [33:0]           lrd_in;
   logic signed [50:0]           sp;
   logic signed [W_W:0]          wsum;
   logic signed [W_W-1:0]        w_in;

   always_comb begin
      w_cur    = w_ff[col];
      mac_prod = w_cur * x_sel;
      sum_sh   = acc_ff[ACC_W-1:12];
      if (sum_sh > (ACC_W-12)'(SUM_MAX)) begin
         sum_cl = SUM_MAX;
      end else if (sum_sh < (ACC_W-12)'(SUM_MIN)) begin
         sum_cl = SUM_MIN;
      end else begin
         sum_cl = sum_sh[19:0];
      end
      offs     = {~sum_cl[19], sum_cl[18:0]};
      idx_prod = (20+DW)'(offs) * (20+DW)'(DEPTH_U);
      err_in   = $signed({1'b0, target_bit, 16'b0}) - $signed({2'b0, act_ff});
      aa_in    = {17'b0, act_ff} * (33'h10000 - {17'b0, act_ff});
      ep       = 50'(err_ff) * $signed({19'b0, aa_ff});
      lrd_in   = $signed({18'b0, learning_rate}) * 34'(delta_ff);
      sp       = 51'(lrd_ff) * 51'(x_sel);
      wsum     = (W_W+1)'(w_cur) + (W_W+1)'(step_ff);
      if (wsum > (W_W+1)'(W_MAX)) begin
         w_in = W_MAX;
      end else if (wsum < (W_W+1)'(W_MIN)) begin
         w_in = W_MIN;
      end else begin
         w_in = wsum[W_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROW_LEN; i++) begin
            w_ff[i] <= '0;
         end
      end else begin
         if (load_en) begin
            w_ff[load_col] <= load_value;
         end
         if (ctrl.uadd_en) begin
            w_ff[col] <= w_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear_acc) begin
         acc_ff <= '0;
      end else if (ctrl.mac_en) begin
         acc_ff <= acc_ff + ACC_W'(mac_prod);
      end
      if (ctrl.sum_en) begin
         idx_ff <= idx_prod[20 +: AW];
      end
      if (ctrl.look_en) begin
         act_ff <= sig_tab[idx_ff];
      end
      if (ctrl.delta_a_en) begin
         err_ff <= err_in;
         aa_ff  <= aa_in[30:0];
      end
      if (ctrl.delta_b_en) begin
         delta_ff <= ep[48:32];
      end
      if (ctrl.rate_en) begin
         lrd_ff <= lrd_in;
      end
      if (ctrl.umul_en) begin
         step_ff <= sp[50:28];
      end
   end

   assign activation = act_ff;

endmodule

`default_nettype wire

// ===== rtl/core/slsgd_merge.sv =====
// ---------------------------------------------------------------------------
// slsgd_merge: combines the lane activations
// Picks the class with the largest activation, lowest index on ties, and
// checks it against the label.
// ---------------------------------------------------------------------------
`default_nettype none

module slsgd_merge (
   input  wire logic [slsgd_pkg::ACT_W-1:0]       acts [slsgd_pkg::NUM_CLASSES],
   input  wire logic [slsgd_pkg::NUM_CLASSES-1:0] label,
   output logic [slsgd_pkg::CLS_W-1:0]            best,
   output logic                                   hit
);
   import slsgd_pkg::*;

   logic [ACT_W-1:0] best_val;

   always_comb begin
      best     = '0;
      best_val = acts[0];
      for (int j = 1; j < NUM_CLASSES; j++) begin
         if (acts[j] > best_val) begin
            best     = CLS_W'(j);
            best_val = acts[j];
         end
      end
      hit = label[best];
   end

endmodule

`default_nettype wire

// ===== rtl/core/sigmoid_layer_sgd_trainer_core.sv =====
// ---------------------------------------------------------------------------
// sigmoid_layer_sgd_trainer_core: single sigmoid layer with online training
// Load and clear words go straight to the result stage; infer words run
// the multiply-accumulate sweep over the five inputs, the sum, the table
// look-up and the evaluation; train words then form the delta, scale it by
// the learning rate and update each weight with a multiply and an add.
// One word is in work at a time. Reset clears the weights, the correct
// count and the result valid flag, and sets the learning rate to 0.1.
// ---------------------------------------------------------------------------
`default_nettype none

module sigmoid_layer_sgd_trainer_core #(
   parameter int SIGMOID_TABLE_DEPTH = 256
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      req_valid,
   output logic                                           req_stall,
   input  wire logic [1:0]                                req_mode,
   input  wire logic signed [slsgd_pkg::F_W-1:0]          req_feature_0,
   input  wire logic signed [slsgd_pkg::F_W-1:0]          req_feature_1,
   input  wire logic signed [slsgd_pkg::F_W-1:0]          req_feature_2,
   input  wire logic signed [slsgd_pkg::F_W-1:0]          req_feature_3,
   input  wire logic [slsgd_pkg::NUM_CLASSES-1:0]         req_label_onehot,
   input  wire logic [slsgd_pkg::IDX_W-1:0]               req_weight_index,
   input  wire logic signed [slsgd_pkg::W_W-1:0]          req_weight_value,
   output logic                                           rsp_valid,
   input  wire logic                                      rsp_stall,
   output logic [slsgd_pkg::CLS_W-1:0]                    rsp_class_index,
   output logic                                           rsp_correct,
   output logic [slsgd_pkg::CNT_W-1:0]                    rsp_correct_count,
   output logic [slsgd_pkg::ACT_W-1:0]                    rsp_activation_0,
   output logic [slsgd_pkg::ACT_W-1:0]                    rsp_activation_1,
   output logic [slsgd_pkg::ACT_W-1:0]                    rsp_activation_2,
   input  wire logic                                      csr_wr_en,
   input  wire logic [slsgd_pkg::LR_W-1:0]                csr_wr_data
);
   import slsgd_pkg::*;

   state_type                 state_ff, state_in;
   logic [COL_W-1:0]          col_ff, col_in;
   logic [1:0]                mode_ff;
   logic [NUM_CLASSES-1:0]    label_ff;
   logic signed [X_W-1:0]     x_ff [ROW_LEN];
   logic [LR_W-1:0]           lr_ff;
   logic [CNT_W-1:0]          hit_ff;
   logic [CLS_W-1:0]          best_ff;
   logic                      hitflag_ff;
   logic                      rsp_valid_ff;
   logic [CLS_W-1:0]          rsp_class_ff;
   logic                      rsp_correct_ff;
   logic [CNT_W-1:0]          rsp_count_ff;
   logic [ACT_W-1:0]          rsp_act_ff [NUM_CLASSES];

   lane_ctrl_type             ctrl;
   logic                      accept;
   logic                      eval_en;
   logic                      out_load;
   logic [NUM_CLASSES-1:0]    load_hit;
   logic [COL_W-1:0]          load_col;
   logic [ACT_W-1:0]          acts [NUM_CLASSES];
   logic [CLS_W-1:0]          best;
   logic                      hit;
   logic signed [F_W-1:0]     feats [NUM_FEATURES];

   assign feats[0] = req_feature_0;
   assign feats[1] = req_feature_1;
   assign feats[2] = req_feature_2;
   assign feats[3] = req_feature_3;

   assign accept = req_valid && !req_stall;

   always_comb begin
      load_hit = '0;
      load_col = '0;
      for (int j = 0; j < NUM_CLASSES; j++) begin
         for (int i = 0; i < ROW_LEN; i++) begin
            if (req_weight_index == IDX_W'(j * ROW_LEN + i)) begin
               load_hit[j] = 1'b1;
               load_col    = COL_W'(i);
            end
         end
      end
   end

   for (genvar j = 0; j < NUM_CLASSES; j++) begin : g_lane
      slsgd_lane #(
         .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
      ) u_lane (
         .clock         (clock),
         .reset         (reset),
         .ctrl          (ctrl),
         .col           (col_ff),
         .x_sel         (x_ff[col_ff]),
         .target_bit    (label_ff[j]),
         .learning_rate (lr_ff),
         .load_en       (accept && (req_mode == MODE_LOAD) && load_hit[j]),
         .load_col      (load_col),
         .load_value    (req_weight_value),
         .activation    (acts[j])
      );
   end

   slsgd_merge u_merge (
      .acts  (acts),
      .label (label_ff),
      .best  (best),
      .hit   (hit)
   );

   always_comb begin
      state_in  = state_ff;
      col_in    = col_ff;
      ctrl      = '0;
      eval_en   = 1'b0;
      out_load  = 1'b0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_mode == MODE_LOAD || req_mode == MODE_CLEAR) begin
                  state_in = ST_DONE;
               end else begin
                  ctrl.clear_acc = 1'b1;
                  col_in         = '0;
                  state_in       = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            ctrl.mac_en = 1'b1;
            if (col_ff == COL_W'(ROW_LEN - 1)) begin
               state_in = ST_SUM;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_SUM: begin
            ctrl.sum_en = 1'b1;
            state_in    = ST_LOOK;
         end
         ST_LOOK: begin
            ctrl.look_en = 1'b1;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            eval_en  = 1'b1;
            state_in = (mode_ff == MODE_TRAIN) ? ST_DELTA_A : ST_DONE;
         end
         ST_DELTA_A: begin
            ctrl.delta_a_en = 1'b1;
            state_in        = ST_DELTA_B;
         end
         ST_DELTA_B: begin
            ctrl.delta_b_en = 1'b1;
            state_in        = ST_RATE;
         end
         ST_RATE: begin
            ctrl.rate_en = 1'b1;
            col_in       = '0;
            state_in     = ST_UMUL;
         end
         ST_UMUL: begin
            ctrl.umul_en = 1'b1;
            state_in     = ST_UADD;
         end
         ST_UADD: begin
            ctrl.uadd_en = 1'b1;
            if (col_ff == COL_W'(ROW_LEN - 1)) begin
               state_in = ST_DONE;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = ST_UMUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         lr_ff        <= LR_RESET;
         hit_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         if (csr_wr_en) begin
            lr_ff <= csr_wr_data;
         end
         if (accept && req_mode == MODE_CLEAR) begin
            hit_ff <= '0;
         end else if (eval_en && mode_ff == MODE_INFER && hit && hit_ff != CNT_FULL) begin
            hit_ff <= hit_ff + 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff  <= req_mode;
         label_ff <= req_label_onehot;
         x_ff[0]  <= BIAS_X;
         for (int i = 0; i < NUM_FEATURES; i++) begin
            x_ff[i+1] <= X_W'(feats[i]);
         end
      end
      if (eval_en) begin
         best_ff    <= best;
         hitflag_ff <= hit;
      end
      if (out_load) begin
         rsp_count_ff <= hit_ff;
         if (mode_ff == MODE_TRAIN || mode_ff == MODE_INFER) begin
            rsp_class_ff   <= best_ff;
            rsp_correct_ff <= hitflag_ff;
            for (int j = 0; j < NUM_CLASSES; j++) begin
               rsp_act_ff[j] <= acts[j];
            end
         end else begin
            rsp_class_ff   <= '0;
            rsp_correct_ff <= 1'b0;
            for (int j = 0; j < NUM_CLASSES; j++) begin
               rsp_act_ff[j] <= '0;
            end
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_class_index   = rsp_class_ff;
   assign rsp_correct       = rsp_correct_ff;
   assign rsp_correct_count = rsp_count_ff;
   assign rsp_activation_0  = rsp_act_ff[0];
   assign rsp_activation_1  = rsp_act_ff[1];
   assign rsp_activation_2  = rsp_act_ff[2];

endmodule

`default_nettype wire

// ===== rtl/core/slsgd_checker.sv =====
// ---------------------------------------------------------------------------
// slsgd_checker: port-level checks of the sigmoid layer trainer
// Watches the request and result channels of the top level over time.
// ---------------------------------------------------------------------------
`default_nettype none

module slsgd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [1:0]  rsp_class_index,
   input wire logic [15:0] rsp_correct_count
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_correct_count)
         && $stable(rsp_class_index))
      else $error("stalled result word changed");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted while one is in work");

   a_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_class_index != 2'd3)
      else $error("class index out of range");

endmodule

bind sigmoid_layer_sgd_trainer_core slsgd_checker u_slsgd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_class_index   (rsp_class_index),
   .rsp_correct_count (rsp_correct_count)
);

`default_nettype wire
